// ----- hdl/rbgm_pkg.sv -----
// shared types, constants and channel helpers for the row glow block
package rbgm_pkg;

	localparam int PIX_W  = 24;
	localparam int CHAN_W = 8;

	// configuration port shape and register indexes
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 4;
	localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GLOW_SHIFT = 1'b1;

	// pixel formats
	localparam logic MODE_RGB888 = 1'b0;
	localparam logic MODE_RGB555 = 1'b1;

	localparam logic [3:0] BIAS_RGB888    = 4'd1;
	localparam logic [3:0] BIAS_RGB555    = 4'd13;
	localparam logic [3:0] GLOW_SHIFT_RST = 4'd7;

	localparam logic [CHAN_W-1:0] CHAN_MASK_RGB888 = 8'hff;
	localparam logic [CHAN_W-1:0] CHAN_MASK_RGB555 = 8'h1f;

	// transaction payloads
	typedef struct packed {
		logic [PIX_W-1:0] pixel_in;
		logic             row_end;
	} src_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel_out;
		logic             row_done;
	} dst_item_t;

	// row sequencing
	typedef enum logic [1:0] {
		ST_RUN,
		ST_FLUSH,
		ST_DRAIN
	} row_state_t;

	// result pending behind the cell row
	typedef struct packed {
		logic vld;
		logic done;
	} stage_ctl_t;

	// clear the bits that the format does not use
	function automatic logic [PIX_W-1:0] pix_mask(input logic [PIX_W-1:0] p, input logic mode);
		return (mode == MODE_RGB555) ? {9'd0, p[14:0]} : p;
	endfunction

	// one colour channel, 0 = blue, 1 = green, 2 = red
	function automatic logic [CHAN_W-1:0] chan_get(input logic [PIX_W-1:0] p, input logic mode,
			input logic [1:0] c);
		logic [CHAN_W-1:0] v;
		case (c)
			2'd0: begin
				v = (mode == MODE_RGB555) ? {3'd0, p[4:0]} : p[7:0];
			end
			2'd1: begin
				v = (mode == MODE_RGB555) ? {3'd0, p[9:5]} : p[15:8];
			end
			2'd2: begin
				v = (mode == MODE_RGB555) ? {3'd0, p[14:10]} : p[23:16];
			end
			default: begin
				v = '0;
			end
		endcase
		return v;
	endfunction

	function automatic logic [3:0] mode_bias(input logic mode);
		return (mode == MODE_RGB555) ? BIAS_RGB555 : BIAS_RGB888;
	endfunction

	function automatic logic [CHAN_W-1:0] chan_mask(input logic mode);
		return (mode == MODE_RGB555) ? CHAN_MASK_RGB555 : CHAN_MASK_RGB888;
	endfunction

endpackage

// ----- hdl/rbgm_cell.sv -----
// one pixel cell of the window shift row
module rbgm_cell
	import rbgm_pkg::*;
(
	input  logic             clk,
	input  logic             advance,
	input  logic [PIX_W-1:0] pix_prev,
	output logic [PIX_W-1:0] pix
);

	logic [PIX_W-1:0] pix_q;

	// take the neighbour's pixel whenever the row moves
	always_ff @(posedge clk) begin
		if (advance) begin
			pix_q <= pix_prev;
		end
	end

	assign pix = pix_q;

endmodule

// ----- hdl/rbgm_sums.sv -----
// running per-channel window sums
module rbgm_sums
	import rbgm_pkg::*;
#(
	parameter int SUM_W = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  mode,
	input  logic                  restart,
	input  logic                  restart_mode,
	input  logic                  advance,
	input  logic [PIX_W-1:0]      add_pix,
	input  logic                  sub_en,
	input  logic [PIX_W-1:0]      sub_pix,
	output logic [2:0][SUM_W-1:0] sums
);

	for (genvar c = 0; c < 3; c++) begin : g_chan
		logic [SUM_W-1:0] sum_q;
		logic [SUM_W-1:0] add_v;
		logic [SUM_W-1:0] sub_v;

		// entering pixel in, pixel leaving the window out
		assign add_v = SUM_W'(chan_get(add_pix, mode, 2'(c)));
		assign sub_v = sub_en ? SUM_W'(chan_get(sub_pix, mode, 2'(c))) : '0;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sum_q <= SUM_W'(mode_bias(MODE_RGB888));
			end else if (restart) begin
				sum_q <= SUM_W'(mode_bias(restart_mode));
			end else if (advance) begin
				sum_q <= sum_q + add_v - sub_v;
			end
		end

		assign sums[c] = sum_q;
	end

endmodule

// ----- hdl/rbgm_compose.sv -----
// glow from the window sums, per-channel max and the output register
module rbgm_compose
	import rbgm_pkg::*;
#(
	parameter int SUM_W = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  stage_ctl_t            s1,
	input  logic [PIX_W-1:0]      centre_pix,
	input  logic [2:0][SUM_W-1:0] sums,
	input  logic                  mode,
	input  logic [3:0]            glow_shift,
	input  logic                  dst_ready,
	output logic                  dst_valid,
	output dst_item_t             dst,
	output logic                  take
);

	logic                     dst_valid_q;
	dst_item_t                dst_q;
	logic [2:0][CHAN_W-1:0]   chan_max;
	logic [PIX_W-1:0]         pix_new;

	assign take = s1.vld && (!dst_valid_q || dst_ready);

	// glow per channel, cut to channel width, then max against the centre pixel
	always_comb begin
		logic [SUM_W-1:0]  shifted;
		logic [CHAN_W-1:0] glow;
		logic [CHAN_W-1:0] orig;
		for (int c = 0; c < 3; c++) begin
			shifted     = sums[c] >> glow_shift;
			glow        = shifted[CHAN_W-1:0] & chan_mask(mode);
			orig        = chan_get(centre_pix, mode, 2'(c));
			chan_max[c] = (glow > orig) ? glow : orig;
		end
		if (mode == MODE_RGB555) begin
			pix_new = {9'd0, chan_max[2][4:0], chan_max[1][4:0], chan_max[0][4:0]};
		end else begin
			pix_new = {chan_max[2], chan_max[1], chan_max[0]};
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dst_valid_q <= 1'b0;
		end else if (take) begin
			dst_valid_q <= 1'b1;
		end else if (dst_ready) begin
			dst_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dst_q.pixel_out <= pix_new;
			dst_q.row_done  <= s1.done;
		end
	end

	assign dst_valid = dst_valid_q;
	assign dst       = dst_q;

endmodule

// ----- hdl/row_box_glow_max_compose_top.sv -----
// top level of the horizontal row glow: cell row, sums, sequencing, output
//
//  channel | handshake                  | payload
//  --------+----------------------------+------------------------------------
//  src     | src_valid / src_ready      | pixel_in[23:0], row_end
//  dst     | dst_valid / dst_ready      | pixel_out[23:0], row_done
//  cfg     | cfg_we (no wait)           | cfg_index[0:0], cfg_data[3:0]
//
// while the cell row is not held it takes one pixel per cycle as a row streams,
// and after row_end one of HALF_WINDOW empty flush slots per cycle; the next row's
// first pixel waits until the final result is taken. a result passes the pending
// slot and output register once the pixel HALF_WINDOW places ahead has entered
// the cell row. a stall on dst holds the cell row once the pending result slot is
// full. reset clears configuration to RGB888 / shift 7 and starts an empty row.
module row_box_glow_max_compose_top
	import rbgm_pkg::*;
#(
	parameter int HALF_WINDOW = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  src_valid,
	output logic                  src_ready,
	input  src_item_t             src,
	output logic                  dst_valid,
	input  logic                  dst_ready,
	output dst_item_t             dst,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int WIN    = 2 * HALF_WINDOW;
	localparam int FILL_W = $clog2(WIN + 1);
	localparam int STEP_W = (HALF_WINDOW > 1) ? $clog2(HALF_WINDOW) : 1;
	localparam int SUM_W  = $clog2(255 * WIN + 14);

	logic                  color_mode_q;
	logic [3:0]            glow_shift_q;
	logic                  mode_write;
	logic                  restart_mode;

	row_state_t            state_q;
	row_state_t            state_nxt;
	logic [FILL_W-1:0]     fill_q;
	logic [FILL_W-1:0]     fill_nxt;
	logic [STEP_W-1:0]     step_q;
	stage_ctl_t            stage_s1;

	logic                  src_take;
	logic                  flush_adv;
	logic                  row_restart;
	logic                  out_take;
	logic                  s1_free;
	logic                  last_step;
	logic                  chain_adv;
	logic                  emit;
	logic                  sub_en;
	logic [FILL_W:0]       flush_pos;
	logic [PIX_W-1:0]      shift_in;
	logic [PIX_W-1:0]      chain_pix [WIN];
	logic [2:0][SUM_W-1:0] sums;

	// configuration registers
	assign mode_write   = cfg_we && (cfg_index == CFG_COLOR_MODE);
	assign restart_mode = mode_write ? cfg_data[0] : color_mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= MODE_RGB888;
			glow_shift_q <= GLOW_SHIFT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_COLOR_MODE: begin
					color_mode_q <= cfg_data[0];
				end
				CFG_GLOW_SHIFT: begin
					glow_shift_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// row position bookkeeping
	assign s1_free   = !stage_s1.vld || out_take;
	assign src_take  = src_valid && src_ready;
	assign chain_adv = src_take || flush_adv;
	assign last_step = (step_q == STEP_W'(HALF_WINDOW - 1));
	assign fill_nxt  = (fill_q == FILL_W'(WIN)) ? fill_q : fill_q + 1'b1;
	assign flush_pos = (FILL_W + 1)'(fill_q) + (FILL_W + 1)'(step_q);

	// a result appears when the centre cell holds a pixel of this row
	assign emit   = src_take ? (fill_nxt > FILL_W'(HALF_WINDOW))
	                         : (flush_pos >= (FILL_W + 1)'(HALF_WINDOW));
	// the last cell leaves the window when it holds a pixel of this row
	assign sub_en = src_take ? (fill_q == FILL_W'(WIN))
	                         : (flush_pos >= (FILL_W + 1)'(WIN));

	assign shift_in = flush_adv ? '0 : pix_mask(src.pixel_in, color_mode_q);

	// row sequencer: next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_RUN: begin
				if (src_take && src.row_end) begin
					state_nxt = ST_FLUSH;
				end
			end
			ST_FLUSH: begin
				if (flush_adv && last_step) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (out_take) begin
					state_nxt = ST_RUN;
				end
			end
			default: begin
				state_nxt = ST_RUN;
			end
		endcase
	end

	// row sequencer: outputs
	always_comb begin
		src_ready   = 1'b0;
		flush_adv   = 1'b0;
		row_restart = mode_write;
		case (state_q)
			ST_RUN: begin
				src_ready = s1_free;
			end
			ST_FLUSH: begin
				flush_adv = s1_free;
			end
			ST_DRAIN: begin
				row_restart = out_take || mode_write;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RUN;
			fill_q  <= '0;
			step_q  <= '0;
		end else begin
			state_q <= state_nxt;
			if (row_restart) begin
				fill_q <= '0;
			end else if (src_take) begin
				fill_q <= fill_nxt;
			end
			if (src_take) begin
				step_q <= '0;
			end else if (flush_adv) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	// pending result slot between cell row and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_s1 <= '0;
		end else if (chain_adv) begin
			stage_s1.vld  <= emit;
			stage_s1.done <= flush_adv && last_step;
		end else if (out_take) begin
			stage_s1.vld <= 1'b0;
		end
	end

	// window cell row, newest pixel in cell 0
	for (genvar i = 0; i < WIN; i++) begin : g_cell
		if (i == 0) begin : g_head
			rbgm_cell u_cell (
				.clk      (clk),
				.advance  (chain_adv),
				.pix_prev (shift_in),
				.pix      (chain_pix[i])
			);
		end else begin : g_body
			rbgm_cell u_cell (
				.clk      (clk),
				.advance  (chain_adv),
				.pix_prev (chain_pix[i-1]),
				.pix      (chain_pix[i])
			);
		end
	end

	rbgm_sums #(
		.SUM_W (SUM_W)
	) u_sums (
		.clk          (clk),
		.arst_n       (arst_n),
		.mode         (color_mode_q),
		.restart      (row_restart),
		.restart_mode (restart_mode),
		.advance      (chain_adv),
		.add_pix      (shift_in),
		.sub_en       (sub_en),
		.sub_pix      (chain_pix[WIN-1]),
		.sums         (sums)
	);

	rbgm_compose #(
		.SUM_W (SUM_W)
	) u_compose (
		.clk        (clk),
		.arst_n     (arst_n),
		.s1         (stage_s1),
		.centre_pix (chain_pix[HALF_WINDOW]),
		.sums       (sums),
		.mode       (color_mode_q),
		.glow_shift (glow_shift_q),
		.dst_ready  (dst_ready),
		.dst_valid  (dst_valid),
		.dst        (dst),
		.take       (out_take)
	);

	// no pixel is taken in the cycle after a row end
	a_flush_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(src_take && src.row_end) |=> !src_ready)
		else $error("pixel accepted right after row end");

	// the row's final result only waits while draining
	a_done_in_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(stage_s1.vld && stage_s1.done) |-> (state_q == ST_DRAIN))
		else $error("row done pending outside drain");

	// the fill count never passes the window length
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WIN))
		else $error("fill count beyond window");

	// handing over the final result starts a fresh row
	a_restart_after_done: assert property (@(posedge clk) disable iff (!arst_n)
		(out_take && stage_s1.done) |=> (fill_q == '0 && state_q == ST_RUN))
		else $error("row not restarted after final result");

endmodule
